>>> rtl/gn2d_pkg.sv
`default_nettype none
package gn2d_pkg;

    localparam int DEF_MAX_WIDTH = 64;
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_SUB_BITS  = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [1:0] CFG_GRID_ROWS  = 2'd1;
    localparam logic [1:0] CFG_DIVISOR    = 2'd2;

    localparam logic [6:0] RST_GRID_WIDTH = 7'd64;
    localparam logic [6:0] RST_GRID_ROWS  = 7'd64;
    localparam logic [8:0] RST_DIVISOR    = 9'd16;

    localparam int SQRT2_Q16 = 92682;

    typedef logic [255:0][31:0] grad_rom_t;

    function automatic logic [15:0] unit_comp(input int a, input int b);
        longint unsigned mag;
        longint unsigned sum;
        longint unsigned lim;
        longint unsigned odd;
        int lo;
        int hi;
        int mid;
        mag = longint'(a < 0 ? -a : a);
        sum = longint'(a * a + b * b);
        lim = (mag * mag) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 2 * longint'(mid) - 1;
            if (odd * odd * sum <= lim) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return (a < 0) ? 16'(-lo) : 16'(lo);
    endfunction

    function automatic grad_rom_t build_rom();
        grad_rom_t rom;
        int a;
        int b;
        for (int i = 0; i < 256; i++) begin
            a = 2 * (i % 16) - 15;
            b = 2 * (i / 16) - 15;
            rom[i] = {unit_comp(b, a), unit_comp(a, b)};
        end
        return rom;
    endfunction

    localparam grad_rom_t GRAD_ROM = build_rom();

endpackage
`default_nettype wire

>>> rtl/gn2d_ram.sv
`default_nettype none
module gn2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> rtl/gradient_noise_2d_sampler_core.sv
`default_nettype none
// Two-dimensional gradient noise sampler. A load transaction writes one gradient byte into
// the table; an evaluate transaction returns one Q3.13 noise sample. One transaction is
// accepted every clock cycle while the result side keeps up; a sample passes through the input
// register, the 17-step pipelined position divider, the corner read from the gradient memory
// and the fade, blend and scale multiplier stages. The gradient table is held in four copies
// of the same memory so that all four cell corners are read in the same cycle; loads pass down
// the same pipeline and write at the read point, so every transaction sees the table exactly
// as the transactions before it left it. A stalled result holds the whole pipeline. The table
// holds no defined value until written.
module gradient_noise_2d_sampler_core #(
    parameter int MAX_WIDTH = gn2d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_ROWS  = gn2d_pkg::DEF_MAX_ROWS,
    parameter int SUB_BITS  = gn2d_pkg::DEF_SUB_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // table_index[11:0], gradient_byte[19:12], cell_x[25:20], cell_y[31:26],
    // sub_x[39:32], sub_y[47:40]
    input  wire logic [47:0] s_tdata,
    // opcode[0]
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // noise_value[15:0]
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [8:0]  cfg_wdata
);

    localparam int DEPTH = MAX_WIDTH * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = SUB_BITS + 18;
    localparam int NS    = 17;
    localparam logic [15:0] DMAX = 16'(1 << SUB_BITS);

    logic [6:0] grid_width_reg;
    logic [6:0] grid_rows_reg;
    logic [8:0] divisor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg <= gn2d_pkg::RST_GRID_WIDTH;
            grid_rows_reg  <= gn2d_pkg::RST_GRID_ROWS;
            divisor_reg    <= gn2d_pkg::RST_DIVISOR;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                gn2d_pkg::CFG_GRID_WIDTH: grid_width_reg <= cfg_wdata[6:0];
                gn2d_pkg::CFG_GRID_ROWS:  grid_rows_reg  <= cfg_wdata[6:0];
                gn2d_pkg::CFG_DIVISOR:    divisor_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic [8:0]          wc;
    logic [8:0]          hc;
    logic [15:0]         dc;
    logic [15:0]         den_full;
    logic [SUB_BITS-1:0] den;
    logic [RW-1:0]       dd2;

    always_comb begin
        if (grid_width_reg == 7'd0) begin
            wc = 9'd1;
        end else if (9'(grid_width_reg) > 9'(MAX_WIDTH)) begin
            wc = 9'(MAX_WIDTH);
        end else begin
            wc = 9'(grid_width_reg);
        end
        if (grid_rows_reg == 7'd0) begin
            hc = 9'd1;
        end else if (9'(grid_rows_reg) > 9'(MAX_ROWS)) begin
            hc = 9'(MAX_ROWS);
        end else begin
            hc = 9'(grid_rows_reg);
        end
        if (divisor_reg < 9'd2) begin
            dc = 16'd2;
        end else if (16'(divisor_reg) > DMAX) begin
            dc = DMAX;
        end else begin
            dc = 16'(divisor_reg);
        end
        den_full = dc - 16'd1;
        den      = den_full[SUB_BITS-1:0];
        dd2      = RW'({den, 1'b0});
    end

    logic adv;
    logic m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Front pipeline: position division and column wrap.
    logic          fev_reg [0:NS];
    logic          fld_reg [0:NS];
    logic [11:0]   idx_reg [0:NS];
    logic [7:0]    gb_reg  [0:NS];
    logic [5:0]    cy_reg  [0:NS];
    logic [5:0]    xm_reg  [0:NS];
    logic [RW-1:0] rx_reg  [0:NS];
    logic [RW-1:0] ry_reg  [0:NS];
    logic [16:0]   qx_reg  [0:NS];
    logic [16:0]   qy_reg  [0:NS];

    logic [SUB_BITS-1:0] sxm;
    logic [SUB_BITS-1:0] sym;
    logic [SUB_BITS-1:0] sxc;
    logic [SUB_BITS-1:0] syc;

    always_comb begin
        sxm = SUB_BITS'(s_tdata[39:32]);
        sym = SUB_BITS'(s_tdata[47:40]);
        sxc = (sxm > den) ? den : sxm;
        syc = (sym > den) ? den : sym;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fev_reg[0] <= 1'b0;
            fld_reg[0] <= 1'b0;
        end else if (adv) begin
            fev_reg[0] <= s_tvalid && (s_tuser[0] == gn2d_pkg::OP_EVAL);
            fld_reg[0] <= s_tvalid && (s_tuser[0] == gn2d_pkg::OP_LOAD);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            idx_reg[0] <= s_tdata[11:0];
            gb_reg[0]  <= s_tdata[19:12];
            xm_reg[0]  <= s_tdata[25:20];
            cy_reg[0]  <= s_tdata[31:26];
            rx_reg[0]  <= RW'({sxc, 17'd0}) + RW'(den);
            ry_reg[0]  <= RW'({syc, 17'd0}) + RW'(den);
            qx_reg[0]  <= 17'd0;
            qy_reg[0]  <= 17'd0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_div
        localparam int K = NS - 1 - i;
        logic [RW-1:0] dsh;
        logic [RW-1:0] rx_next;
        logic [RW-1:0] ry_next;
        logic [16:0]   qx_next;
        logic [16:0]   qy_next;
        logic [5:0]    xm_next;

        always_comb begin
            dsh     = dd2 << K;
            rx_next = rx_reg[i];
            ry_next = ry_reg[i];
            qx_next = qx_reg[i];
            qy_next = qy_reg[i];
            xm_next = xm_reg[i];
            if (rx_reg[i] >= dsh) begin
                rx_next    = rx_reg[i] - dsh;
                qx_next[K] = 1'b1;
            end
            if (ry_reg[i] >= dsh) begin
                ry_next    = ry_reg[i] - dsh;
                qy_next[K] = 1'b1;
            end
            if (i < 6) begin
                if (16'(xm_reg[i]) >= (16'(wc) << (5 - i))) begin
                    xm_next = 6'(16'(xm_reg[i]) - (16'(wc) << (5 - i)));
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                fev_reg[i+1] <= 1'b0;
                fld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                fev_reg[i+1] <= fev_reg[i];
                fld_reg[i+1] <= fld_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                idx_reg[i+1] <= idx_reg[i];
                gb_reg[i+1]  <= gb_reg[i];
                cy_reg[i+1]  <= cy_reg[i];
                xm_reg[i+1]  <= xm_next;
                rx_reg[i+1]  <= rx_next;
                ry_reg[i+1]  <= ry_next;
                qx_reg[i+1]  <= qx_next;
                qy_reg[i+1]  <= qy_next;
            end
        end
    end

    // Corner addressing: A (x, y), B (x+1, y), C (x+1, y+1), D (x, y+1).
    logic [8:0]  x0;
    logic [8:0]  x1;
    logic [8:0]  y0;
    logic [8:0]  y1;
    logic [8:0]  cxs [0:3];
    logic [8:0]  cys [0:3];
    logic [15:0] caddr [0:3];
    logic [3:0]  cbad;
    logic        wr_en;

    always_comb begin
        x0 = 9'(xm_reg[NS]);
        x1 = x0 + 9'd1;
        if (x1 == wc) begin
            x1 = 9'd0;
        end
        y0 = 9'(cy_reg[NS]);
        y1 = y0 + 9'd1;
        cxs[0] = x0;
        cxs[1] = x1;
        cxs[2] = x1;
        cxs[3] = x0;
        cys[0] = y0;
        cys[1] = y0;
        cys[2] = y1;
        cys[3] = y1;
        for (int k = 0; k < 4; k++) begin
            caddr[k] = 16'(cxs[k]) + 16'(cys[k]) * 16'(wc);
            cbad[k]  = (cys[k] >= hc) || (17'(caddr[k]) >= 17'(DEPTH));
        end
        wr_en = adv && fld_reg[NS] && (17'(idx_reg[NS]) < 17'(DEPTH));
    end

    logic [7:0] ram_q [0:3];

    for (genvar k = 0; k < 4; k++) begin : g_ram
        gn2d_ram #(
            .WIDTH (8),
            .DEPTH (DEPTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (wr_en),
            .wr_addr (AW'(idx_reg[NS])),
            .wr_data (gb_reg[NS]),
            .rd_en   (adv),
            .rd_addr (caddr[k][AW-1:0]),
            .rd_data (ram_q[k])
        );
    end

    function automatic logic signed [55:0] rshift(input logic signed [55:0] x, input int k);
        logic signed [55:0] h;
        h = 56'sd1 <<< (k - 1);
        if (x >= 0) begin
            return (x + h) >>> k;
        end
        return -((-x + h) >>> k);
    endfunction

    // Back pipeline: fade, corner dots, blends and scaling.
    logic [10:1] ev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            ev_reg       <= {ev_reg[9:1], fev_reg[NS]};
            m_tvalid_reg <= ev_reg[10];
        end
    end

    logic [3:0]  bad1_reg;
    logic [16:0] ux1_reg;
    logic [16:0] uy1_reg;
    logic [33:0] uux1_reg;
    logic [33:0] uuy1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            bad1_reg <= cbad;
            ux1_reg  <= qx_reg[NS];
            uy1_reg  <= qy_reg[NS];
            uux1_reg <= 34'(qx_reg[NS]) * 34'(qx_reg[NS]);
            uuy1_reg <= 34'(qy_reg[NS]) * 34'(qy_reg[NS]);
        end
    end

    logic signed [15:0] gx [0:3];
    logic signed [15:0] gy [0:3];
    logic signed [17:0] px1;
    logic signed [17:0] py1;
    logic signed [17:0] qx1;
    logic signed [17:0] qy1;
    logic [7:0]         gbyte;
    logic [37:0]        inx;
    logic [37:0]        iny;
    logic [34:0]        u2xs;
    logic [34:0]        u2ys;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            gbyte = bad1_reg[k] ? 8'hFF : ram_q[k];
            gx[k] = $signed(gn2d_pkg::GRAD_ROM[gbyte][15:0]);
            gy[k] = $signed(gn2d_pkg::GRAD_ROM[gbyte][31:16]);
        end
        px1  = $signed({1'b0, ux1_reg});
        py1  = $signed({1'b0, uy1_reg});
        qx1  = px1 - 18'sd65536;
        qy1  = py1 - 18'sd65536;
        inx  = 38'(uux1_reg) * 38'd6 + (38'd10 << 32) - ((38'(ux1_reg) * 38'd15) << 16);
        iny  = 38'(uuy1_reg) * 38'd6 + (38'd10 << 32) - ((38'(uy1_reg) * 38'd15) << 16);
        u2xs = 35'(uux1_reg) + 35'd32768;
        u2ys = 35'(uuy1_reg) + 35'd32768;
    end

    logic signed [33:0] prod2_reg [0:7];
    logic [19:0]        i16x2_reg;
    logic [19:0]        i16y2_reg;
    logic [16:0]        u2x2_reg;
    logic [16:0]        u2y2_reg;
    logic [16:0]        ux2_reg;
    logic [16:0]        uy2_reg;
    logic [37:0]        inxr;
    logic [37:0]        inyr;

    always_comb begin
        inxr = inx + 38'd32768;
        inyr = iny + 38'd32768;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod2_reg[0] <= gx[0] * px1;
            prod2_reg[1] <= gy[0] * py1;
            prod2_reg[2] <= gx[1] * qx1;
            prod2_reg[3] <= gy[1] * py1;
            prod2_reg[4] <= gx[2] * qx1;
            prod2_reg[5] <= gy[2] * qy1;
            prod2_reg[6] <= gx[3] * px1;
            prod2_reg[7] <= gy[3] * qy1;
            i16x2_reg    <= inxr[35:16];
            i16y2_reg    <= inyr[35:16];
            u2x2_reg     <= u2xs[32:16];
            u2y2_reg     <= u2ys[32:16];
            ux2_reg      <= ux1_reg;
            uy2_reg      <= uy1_reg;
        end
    end

    logic signed [35:0] dot3_reg [0:3];
    logic [19:0]        i16x3_reg;
    logic [19:0]        i16y3_reg;
    logic [16:0]        u3x3_reg;
    logic [16:0]        u3y3_reg;
    logic [34:0]        u3xs;
    logic [34:0]        u3ys;

    always_comb begin
        u3xs = 35'(34'(u2x2_reg) * 34'(ux2_reg)) + 35'd32768;
        u3ys = 35'(34'(u2y2_reg) * 34'(uy2_reg)) + 35'd32768;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                dot3_reg[k] <= 36'(prod2_reg[2*k]) + 36'(prod2_reg[2*k+1]);
            end
            i16x3_reg <= i16x2_reg;
            i16y3_reg <= i16y2_reg;
            u3x3_reg  <= u3xs[32:16];
            u3y3_reg  <= u3ys[32:16];
        end
    end

    logic [37:0] txs;
    logic [37:0] tys;
    logic [16:0] tx;
    logic [16:0] ty;

    always_comb begin
        txs = 38'(37'(u3x3_reg) * 37'(i16x3_reg)) + 38'd32768;
        tys = 38'(37'(u3y3_reg) * 37'(i16y3_reg)) + 38'd32768;
        tx  = (txs[37:16] > 22'd65536) ? 17'd65536 : txs[32:16];
        ty  = (tys[37:16] > 22'd65536) ? 17'd65536 : tys[32:16];
    end

    logic signed [35:0] va4_reg;
    logic signed [35:0] vd4_reg;
    logic signed [35:0] dab4_reg;
    logic signed [35:0] ddc4_reg;
    logic [16:0]        tx4_reg;
    logic [16:0]        ty4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            va4_reg  <= dot3_reg[0];
            vd4_reg  <= dot3_reg[3];
            dab4_reg <= dot3_reg[1] - dot3_reg[0];
            ddc4_reg <= dot3_reg[2] - dot3_reg[3];
            tx4_reg  <= tx;
            ty4_reg  <= ty;
        end
    end

    logic signed [55:0] p15_reg;
    logic signed [55:0] p25_reg;
    logic signed [35:0] va5_reg;
    logic signed [35:0] vd5_reg;
    logic [16:0]        ty5_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p15_reg <= 56'(dab4_reg * $signed({1'b0, tx4_reg}));
            p25_reg <= 56'(ddc4_reg * $signed({1'b0, tx4_reg}));
            va5_reg <= va4_reg;
            vd5_reg <= vd4_reg;
            ty5_reg <= ty4_reg;
        end
    end

    logic signed [55:0] ab6;
    logic signed [55:0] dcl6;

    always_comb begin
        ab6  = 56'(va5_reg) + rshift(p15_reg, 16);
        dcl6 = 56'(vd5_reg) + rshift(p25_reg, 16);
    end

    logic signed [35:0] ab6_reg;
    logic signed [35:0] dcl6_reg;
    logic [16:0]        ty6_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ab6_reg  <= 36'(ab6);
            dcl6_reg <= 36'(dcl6);
            ty6_reg  <= ty5_reg;
        end
    end

    logic signed [35:0] ab7_reg;
    logic signed [35:0] d7_reg;
    logic [16:0]        ty7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            ab7_reg <= ab6_reg;
            d7_reg  <= dcl6_reg - ab6_reg;
            ty7_reg <= ty6_reg;
        end
    end

    logic signed [55:0] p38_reg;
    logic signed [35:0] ab8_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p38_reg <= 56'(d7_reg * $signed({1'b0, ty7_reg}));
            ab8_reg <= ab7_reg;
        end
    end

    logic signed [55:0] r9;
    logic signed [35:0] r9_reg;

    always_comb begin
        r9 = 56'(ab8_reg) + rshift(p38_reg, 16);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r9_reg <= 36'(r9);
        end
    end

    logic signed [55:0] m10_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            m10_reg <= 56'(r9_reg * 18'sd92682);
        end
    end

    logic signed [55:0] o11;
    logic        [15:0] o11_sat;

    always_comb begin
        o11 = rshift(m10_reg, 33);
        if (o11 > 56'sd32767) begin
            o11_sat = 16'h7FFF;
        end else if (o11 < -56'sd32768) begin
            o11_sat = 16'h8000;
        end else begin
            o11_sat = o11[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= o11_sat;
        end
    end

endmodule
`default_nettype wire

>>> rtl/gn2d_checker.sv
`default_nettype none
module gn2d_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // A waiting result must not change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // With no result pending the input side is always open.
    a_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input closed with no result pending");

    // A stalled result holds the input side as well.
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input open while result stalled");

    // Nothing is presented straight out of reset.
    a_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result presented after reset");

endmodule

bind gradient_noise_2d_sampler_core gn2d_checker u_gn2d_checker (.*);
`default_nettype wire
